[design/acw_pkg.sv]
// ----------------------------------------------------------------------------
// AIMD congestion window package
// Shared constants, types and helpers for the congestion window block.
// ----------------------------------------------------------------------------
package acw_pkg;

    localparam int TABLE_ENTRIES   = 256;
    localparam int IDX_W           = $clog2(TABLE_ENTRIES);
    localparam int CNT_W           = IDX_W + 1;
    localparam int INITIAL_MIN_RTT = 1500;

    localparam int WIN_W     = 24;
    localparam int DVD_W     = 32;
    localparam int DIV_STEPS = DVD_W;

    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_DECREASE = 2'd1;
    localparam logic [1:0] CFG_INCREASE = 2'd2;
    localparam logic [1:0] CFG_FLOOR    = 2'd3;

    localparam logic [15:0] RST_TIMEOUT  = 16'd117;
    localparam logic [11:0] RST_DECREASE = 12'd410;
    localparam logic [9:0]  RST_INCREASE = 10'd212;
    localparam logic [15:0] RST_FLOOR    = 16'd768;

    typedef struct packed {
        logic             valid;
        logic [DVD_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             valid;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             valid;
        logic [WIN_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
        logic [WIN_W-1:0] dsr;
    } t_div_stage;

    function automatic logic [WIN_W-1:0] sat_win(input logic [DVD_W:0] v);
        logic [WIN_W-1:0] r;
        if (v > {{(DVD_W+1-WIN_W){1'b0}}, {WIN_W{1'b1}}}) begin
            r = {WIN_W{1'b1}};
        end else begin
            r = v[WIN_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/aimd_congestion_window.sv]
// ----------------------------------------------------------------------------
// AIMD congestion window
// Tracks outstanding packets and adjusts a Q16.8 congestion window.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low, and its result
// appears on o_valid for exactly one cycle; the receiver cannot stall it. A
// sent event leaves the block in its idle state, ready for the next one. An
// ack keeps the block busy until its result is out: the timeout scan reads
// the packet table one entry per cycle through its single port, and each
// window division passes a 32-cell divider chain.
module aimd_congestion_window
    import acw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [31:0] i_seq_num,
    input  logic [31:0] i_sent_at,
    input  logic [31:0] i_acked_at,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_window_packets,
    output logic [31:0] o_rtt_ms,
    output logic        o_decreased,
    output logic [31:0] o_shortest_rtt
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GROW_GO = 4'd1;
    localparam logic [3:0] S_GROW_WT = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_RM      = 4'd4;
    localparam logic [3:0] S_SCHK    = 4'd5;
    localparam logic [3:0] S_SCAN    = 4'd6;
    localparam logic [3:0] S_SHR_GO  = 4'd7;
    localparam logic [3:0] S_SHR_WT  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]         r_state;
    logic [15:0]        r_timeout;
    logic [11:0]        r_decrease;
    logic [9:0]         r_increase;
    logic [15:0]        r_floor;
    logic [WIN_W-1:0]   r_window;
    logic [31:0]        r_min_rtt;
    logic [31:0]        r_last_scan;
    logic               r_slow;
    logic [TABLE_ENTRIES-1:0] r_entry_vld;
    logic [63:0]        r_mem [0:TABLE_ENTRIES-1];
    logic [63:0]        r_rd_data;
    logic [31:0]        r_seq;
    logic [31:0]        r_now;
    logic [31:0]        r_rtt;
    logic               r_late;
    logic               r_dec;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend;
    logic               r_vld_d;
    logic               r_hit;
    logic               r_out_vld;
    logic [15:0]        r_out_win;
    logic [31:0]        r_out_rtt;
    logic               r_out_dec;
    logic [31:0]        r_out_min;

    logic [31:0]        n_rtt;
    logic [31:0]        n_min;
    logic               w_accept;
    logic               w_we;
    logic [IDX_W-1:0]   w_addr;
    logic [IDX_W-1:0]   w_slot;
    logic               w_scan_hit;
    logic [31:0]        w_age;
    t_div_req           w_req;
    t_div_rsp           w_rsp;
    logic [WIN_W-1:0]   w_shrunk;

    assign w_accept = i_start && !o_busy;
    assign o_busy   = r_state != S_IDLE;
    assign n_rtt    = i_acked_at - i_sent_at;
    assign n_min    = (n_rtt < r_min_rtt) ? n_rtt : r_min_rtt;
    assign w_slot   = r_seq[IDX_W-1:0];
    assign w_we     = w_accept && !i_mode;
    assign w_addr   = w_we ? i_seq_num[IDX_W-1:0] :
                      (r_state == S_SCAN) ? r_cnt[IDX_W-1:0] : w_slot;
    assign w_age    = r_now - r_rd_data[31:0];
    assign w_scan_hit = r_pend && r_vld_d && (w_age > {16'd0, r_timeout});

    always_comb begin
        w_req.valid    = (r_state == S_GROW_GO) || (r_state == S_SHR_GO);
        w_req.dividend = '0;
        w_req.divisor  = '0;
        if (r_state == S_SHR_GO) begin
            w_req.dividend = {r_window, 8'd0};
            w_req.divisor  = (r_decrease != 12'd0) ? {12'd0, r_decrease} : WIN_W'(1);
        end else begin
            w_req.dividend = {14'd0, r_increase, 8'd0};
            w_req.divisor  = (r_window != '0) ? r_window : WIN_W'(1);
        end
    end

    acw_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_shrunk = sat_win({1'b0, w_rsp.quotient});
        if (w_shrunk < {8'd0, r_floor}) begin
            w_shrunk = {8'd0, r_floor};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= {i_seq_num, i_sent_at};
        end
        r_rd_data <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= RST_TIMEOUT;
            r_decrease <= RST_DECREASE;
            r_increase <= RST_INCREASE;
            r_floor    <= RST_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                CFG_DECREASE: r_decrease <= i_cfg_data[11:0];
                CFG_INCREASE: r_increase <= i_cfg_data[9:0];
                CFG_FLOOR:    r_floor    <= i_cfg_data;
                default:      r_floor    <= r_floor;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_W'(RST_FLOOR);
            r_min_rtt   <= 32'(INITIAL_MIN_RTT);
            r_last_scan <= '0;
            r_slow      <= 1'b1;
            r_entry_vld <= '0;
            r_out_vld   <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_dec       <= 1'b0;
            r_late      <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_seq <= i_seq_num;
                        r_now <= i_now_ms;
                        r_dec <= 1'b0;
                        if (!i_mode) begin
                            r_entry_vld[i_seq_num[IDX_W-1:0]] <= 1'b1;
                            r_out_vld <= 1'b1;
                            r_out_win <= r_window[WIN_W-1:8];
                            r_out_rtt <= '0;
                            r_out_dec <= 1'b0;
                            r_out_min <= r_min_rtt;
                        end else begin
                            r_rtt     <= n_rtt;
                            r_min_rtt <= n_min;
                            r_late    <= !(n_rtt < {16'd0, r_timeout});
                            if (n_rtt < {16'd0, r_timeout}) begin
                                if (r_slow) begin
                                    r_window <= sat_win({9'd0, r_window}
                                                        + {23'd0, r_increase});
                                    r_state  <= S_RD;
                                end else begin
                                    r_state <= S_GROW_GO;
                                end
                            end else if (i_seq_num != 32'd0) begin
                                r_state <= S_SCHK;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_GROW_GO: r_state <= S_GROW_WT;
                S_GROW_WT: begin
                    if (w_rsp.valid) begin
                        r_window <= sat_win({9'd0, r_window} + {1'b0, w_rsp.quotient});
                        r_state  <= S_RD;
                    end
                end
                S_RD: r_state <= S_RM;
                S_RM: begin
                    if (r_entry_vld[w_slot] && (r_rd_data[63:32] == r_seq)) begin
                        r_entry_vld[w_slot] <= 1'b0;
                    end
                    r_state <= r_late ? S_DONE : S_SCHK;
                end
                S_SCHK: begin
                    if ((r_now - r_last_scan) > r_min_rtt) begin
                        r_last_scan <= r_now;
                        r_cnt       <= '0;
                        r_pend      <= 1'b0;
                        r_hit       <= 1'b0;
                        r_state     <= S_SCAN;
                    end else begin
                        r_state <= r_late ? S_RD : S_DONE;
                    end
                end
                S_SCAN: begin
                    r_pend  <= r_cnt < CNT_W'(TABLE_ENTRIES);
                    r_vld_d <= r_entry_vld[r_cnt[IDX_W-1:0]];
                    if (w_scan_hit) begin
                        r_hit <= 1'b1;
                    end
                    if (r_cnt < CNT_W'(TABLE_ENTRIES)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (r_hit || w_scan_hit) begin
                        r_state <= S_SHR_GO;
                    end else begin
                        r_state <= r_late ? S_RD : S_DONE;
                    end
                end
                S_SHR_GO: r_state <= S_SHR_WT;
                S_SHR_WT: begin
                    if (w_rsp.valid) begin
                        r_window <= w_shrunk;
                        r_slow   <= 1'b0;
                        r_dec    <= 1'b1;
                        r_state  <= r_late ? S_RD : S_DONE;
                    end
                end
                S_DONE: begin
                    r_out_vld <= 1'b1;
                    r_out_win <= r_window[WIN_W-1:8];
                    r_out_rtt <= r_rtt;
                    r_out_dec <= r_dec;
                    r_out_min <= r_min_rtt;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_vld;
    assign o_window_packets = r_out_win;
    assign o_rtt_ms         = r_out_rtt;
    assign o_decreased      = r_out_dec;
    assign o_shortest_rtt   = r_out_min;

    a_sent_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_mode) |=> o_valid)
        else $error("sent request produced no result");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == S_GROW_WT || r_state == S_SHR_WT))
        else $error("divider answered outside a wait state");

    a_dec_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_decreased) |-> (o_window_packets >= {8'd0, r_floor[15:8]}))
        else $error("decreased window below floor");

endmodule

[design/acw_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step; hands its partial result to the next cell.
// ----------------------------------------------------------------------------
module acw_div_cell
    import acw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);

    logic [WIN_W:0] w_trial;
    logic [WIN_W:0] w_diff;
    logic           w_ge;
    t_div_stage     r_stage;

    assign w_trial = {i_stage.rem, i_stage.dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_stage.dsr};
    assign w_diff  = w_trial - {1'b0, i_stage.dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
        r_stage.rem <= w_ge ? w_diff[WIN_W-1:0] : w_trial[WIN_W-1:0];
        r_stage.dvd <= {i_stage.dvd[DVD_W-2:0], 1'b0};
        r_stage.quo <= {i_stage.quo[DVD_W-2:0], w_ge};
        r_stage.dsr <= i_stage.dsr;
    end

    assign o_stage = r_stage;

endmodule

[design/acw_divider.sv]
// ----------------------------------------------------------------------------
// Divider chain
// A row of division cells; one quotient bit is settled in each cell.
// ----------------------------------------------------------------------------
module acw_divider
    import acw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    t_div_stage w_stage [0:DIV_STEPS];

    assign w_stage[0].valid = i_req.valid;
    assign w_stage[0].rem   = '0;
    assign w_stage[0].dvd   = i_req.dividend;
    assign w_stage[0].quo   = '0;
    assign w_stage[0].dsr   = i_req.divisor;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        acw_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[k]),
            .o_stage (w_stage[k+1])
        );
    end

    assign o_rsp.valid    = w_stage[DIV_STEPS].valid;
    assign o_rsp.quotient = w_stage[DIV_STEPS].quo;

endmodule

[verif/tb_aimd_congestion_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AIMD congestion window testbench
// Drives sent and ack requests with bursty timing and checks every result
// against a behavioral model of the window, the packet table and the scan.
// ----------------------------------------------------------------------------
module tb_aimd_congestion_window;
    import acw_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic        mode;
        logic [31:0] seq_num;
        logic [31:0] sent_at;
        logic [31:0] acked_at;
        logic [31:0] now_ms;
    } t_event;

    typedef struct {
        logic [15:0] window_packets;
        logic [31:0] rtt_ms;
        logic        decreased;
        logic [31:0] shortest_rtt;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_mode;
    logic [31:0] i_seq_num;
    logic [31:0] i_sent_at;
    logic [31:0] i_acked_at;
    logic [31:0] i_now_ms;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [15:0] o_window_packets;
    logic [31:0] o_rtt_ms;
    logic        o_decreased;
    logic [31:0] o_shortest_rtt;

    aimd_congestion_window u_dut (.*);

    t_event      pending_events[$];
    t_outcome    expected_outcomes[$];
    int          error_count;
    int          idle_cycles;
    bit          driver_enable;
    int          burst_left;
    int          gap_left;
    bit          accept_seen;

    logic [31:0] tbl_tag[TABLE_ENTRIES];
    logic [31:0] tbl_time[TABLE_ENTRIES];
    bit          tbl_valid[TABLE_ENTRIES];
    logic [23:0] window_q8;
    logic [31:0] min_rtt;
    logic [31:0] last_scan;
    bit          model_slow;
    logic [15:0] timeout_limit;
    logic [11:0] decrease_factor;
    logic [9:0]  increase_step;
    logic [15:0] window_floor;

    // Bookkeeping for stimulus: which tag each slot holds, so acks can match.
    logic [31:0] gen_tag[TABLE_ENTRIES];
    bit          gen_used[TABLE_ENTRIES];
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [23:0] saturate(logic [63:0] v);
        return (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    function automatic bit run_scan(logic [31:0] now);
        bit hit;
        logic [63:0] d;
        logic [23:0] w;
        hit = 0;
        if (now - last_scan > min_rtt) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i] && (now - tbl_time[i]) > {16'd0, timeout_limit}) hit = 1;
            end
            if (hit) begin
                d = (decrease_factor == 0) ? 64'd1 : 64'(decrease_factor);
                w = saturate((64'(window_q8) << 8) / d);
                if (w < 24'(window_floor)) w = 24'(window_floor);
                window_q8 = w;
                model_slow = 0;
            end
            last_scan = now;
        end
        return hit;
    endfunction

    function automatic void drop_entry(logic [31:0] seq);
        if (tbl_valid[seq[7:0]] && tbl_tag[seq[7:0]] == seq) tbl_valid[seq[7:0]] = 0;
    endfunction

    function automatic t_outcome window_update(t_event ev);
        t_outcome r;
        logic [63:0] d;
        r.rtt_ms = 0;
        r.decreased = 0;
        if (!ev.mode) begin
            tbl_tag[ev.seq_num[7:0]] = ev.seq_num;
            tbl_time[ev.seq_num[7:0]] = ev.sent_at;
            tbl_valid[ev.seq_num[7:0]] = 1;
        end else begin
            r.rtt_ms = ev.acked_at - ev.sent_at;
            if (r.rtt_ms < min_rtt) min_rtt = r.rtt_ms;
            if (r.rtt_ms < {16'd0, timeout_limit}) begin
                if (model_slow) begin
                    window_q8 = saturate(64'(window_q8) + 64'(increase_step));
                end else begin
                    d = (window_q8 == 0) ? 64'd1 : 64'(window_q8);
                    window_q8 = saturate(64'(window_q8) + (64'(increase_step) << 8) / d);
                end
                drop_entry(ev.seq_num);
                r.decreased = run_scan(ev.now_ms);
            end else begin
                if (ev.seq_num != 0) r.decreased = run_scan(ev.now_ms);
                drop_entry(ev.seq_num);
            end
        end
        r.window_packets = window_q8[23:8];
        r.shortest_rtt = min_rtt;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic add_event(bit mode, logic [31:0] seq, logic [31:0] sent,
                             logic [31:0] acked, logic [31:0] now);
        t_event ev;
        ev.mode = mode;
        ev.seq_num = seq;
        ev.sent_at = sent;
        ev.acked_at = acked;
        ev.now_ms = now;
        pending_events.push_back(ev);
    endtask

    task automatic add_random_event();
        int kind;
        logic [31:0] seq;
        logic [7:0] slot;
        kind = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 60);
        slot = 8'($urandom_range(0, 31));
        if (kind < 45) begin
            seq = {$urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 15)) << 8};
            seq[7:0] = slot;
            gen_tag[slot] = seq;
            gen_used[slot] = 1;
            add_event(0, seq, clock_ms - $urandom_range(0, 20), $urandom, $urandom);
        end else if (kind < 85 && gen_used[slot]) begin
            add_event(1, gen_tag[slot], clock_ms - $urandom_range(0, 200), clock_ms,
                      clock_ms + $urandom_range(0, 300));
        end else begin
            add_event(1, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom, $urandom, $urandom,
                      $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 0;
        case (idx)
            CFG_TIMEOUT:  timeout_limit = data;
            CFG_DECREASE: decrease_factor = data[11:0];
            CFG_INCREASE: increase_step = data[9:0];
            default:      window_floor = data;
        endcase
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || !driver_enable) begin
            i_start <= 0;
        end else if (i_start && !accept_seen) begin
            i_start <= 1;
        end else if (gap_left > 0 || pending_events.size() == 0) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            i_start <= 0;
        end else begin
            i_start <= 1;
            i_mode <= pending_events[0].mode;
            i_seq_num <= pending_events[0].seq_num;
            i_sent_at <= pending_events[0].sent_at;
            i_acked_at <= pending_events[0].acked_at;
            i_now_ms <= pending_events[0].now_ms;
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_left <= $urandom_range(0, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n) begin
            accept_seen <= i_start && !o_busy;
            if ((i_start && !o_busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_start && !o_busy) begin
                expected_outcomes.push_back(window_update(pending_events.pop_front()));
            end
            if (o_valid) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    exp_r = expected_outcomes.pop_front();
                    if (o_window_packets !== exp_r.window_packets)
                        report_mismatch("window_packets", o_window_packets, exp_r.window_packets);
                    if (o_rtt_ms !== exp_r.rtt_ms)
                        report_mismatch("rtt_ms", o_rtt_ms, exp_r.rtt_ms);
                    if (o_decreased !== exp_r.decreased)
                        report_mismatch("decreased", o_decreased, exp_r.decreased);
                    if (o_shortest_rtt !== exp_r.shortest_rtt)
                        report_mismatch("shortest_rtt", o_shortest_rtt, exp_r.shortest_rtt);
                end
            end
            if (idle_cycles > IDLE_LIMIT) begin
                $display("aimd_congestion_window test failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 0;
        i_start = 0;
        i_mode = 0;
        i_seq_num = 0;
        i_sent_at = 0;
        i_acked_at = 0;
        i_now_ms = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_TIMEOUT;
        i_cfg_data = 0;
        error_count = 0;
        idle_cycles = 0;
        driver_enable = 0;
        burst_left = 0;
        gap_left = 0;
        clock_ms = 1000;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 0;
            tbl_tag[i] = 0;
            tbl_time[i] = 0;
            gen_used[i] = 0;
        end
        window_q8 = 24'(RST_FLOOR);
        min_rtt = INITIAL_MIN_RTT;
        last_scan = 0;
        model_slow = 1;
        timeout_limit = RST_TIMEOUT;
        decrease_factor = RST_DECREASE;
        increase_step = RST_INCREASE;
        window_floor = RST_FLOOR;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extreme fields, slot overwrite, late ack of sequence zero, clock wrap.
        add_event(0, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
        add_event(0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_event(0, 32'h0000_0105, 32'd100, 32'h0, 32'h0);
        add_event(0, 32'h0000_0205, 32'd110, 32'h0, 32'h0);
        add_event(1, 32'h0000_0105, 32'd100, 32'd150, 32'd160);
        add_event(1, 32'h0000_0205, 32'd110, 32'd130, 32'd2000);
        add_event(1, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0020);
        add_event(1, 32'h0000_0000, 32'd0, 32'd5000, 32'd9000);
        add_event(1, 32'h0000_0000, 32'd0, 32'd5, 32'd9100);
        add_event(1, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        add_event(1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        add_event(1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        add_event(0, 32'h0000_0000, 32'd0, 32'h0, 32'h0);
        add_event(1, 32'h0000_0000, 32'd0, 32'd1, 32'd40000);
        driver_enable = 1;
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_TIMEOUT, 16'd1);
                    write_reg(CFG_DECREASE, 16'd257);
                    write_reg(CFG_INCREASE, 16'd1023);
                    write_reg(CFG_FLOOR, 16'd256);
                end
                1: begin
                    write_reg(CFG_TIMEOUT, 16'hFFFF);
                    write_reg(CFG_DECREASE, 16'd4095);
                    write_reg(CFG_INCREASE, 16'd1);
                    write_reg(CFG_FLOOR, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_TIMEOUT, 16'($urandom_range(20, 300)));
                    write_reg(CFG_DECREASE, 16'($urandom_range(257, 4095)));
                    write_reg(CFG_INCREASE, 16'($urandom_range(1, 1023)));
                    write_reg(CFG_FLOOR, 16'($urandom_range(256, 4000)));
                end
                default: begin
                    write_reg(CFG_TIMEOUT, RST_TIMEOUT);
                    write_reg(CFG_DECREASE, RST_DECREASE);
                    write_reg(CFG_INCREASE, RST_INCREASE);
                    write_reg(CFG_FLOOR, RST_FLOOR);
                end
            endcase
            for (int n = 0; n < 180; n++) add_random_event();
            wait_drained();
        end

        driver_enable = 0;
        if (error_count == 0) begin
            $display("aimd_congestion_window test passed");
        end else begin
            $display("aimd_congestion_window test failed");
        end
        $finish;
    end

endmodule
